// ===== rtl/button_press_classifier_core_assert.svh =====
// assertion macros for the button press classifier
// no dependencies; included by the top level
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpc assertion failed");
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bpc assertion failed");
`else
`define BPC_ASSERT(lbl, clk, rst_n, prop)
`define BPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/bpc_pkg.sv =====
// shared types and constants for the button press classifier
// no dependencies
package bpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned PHASE_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 3'd4;

    // register reset values
    localparam logic [MS_W-1:0] RST_DEBOUNCE   = 16'd50;
    localparam logic [MS_W-1:0] RST_LONG_PRESS = 16'd2000;
    localparam logic [MS_W-1:0] RST_DOUBLE_GAP = 16'd250;
    localparam logic [MS_W-1:0] RST_SETTLE     = 16'd500;
    localparam logic            RST_PRESSED_LEVEL = 1'b0;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd3;

    // phase codes; the fourth code behaves as idle
    localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HELD     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd2;
    localparam logic [PHASE_W-1:0] PH_UNUSED   = 2'd3;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] double_gap_ms;
        logic [MS_W-1:0] settle_ms;
        logic            pressed_level;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               short_fired;
        logic               long_fired;
        logic               double_fired;
    } t_status;

endpackage

// ===== rtl/bpc_cfg.sv =====
// configuration register file for the button press classifier
// depends on bpc_pkg
module bpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpc_pkg::MS_W-1:0]       i_cfg_data,
    output bpc_pkg::t_cfg                  o_cfg
);
    import bpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:      n_cfg.debounce_ms   = i_cfg_data;
                CFG_LONG_PRESS:    n_cfg.long_press_ms = i_cfg_data;
                CFG_DOUBLE_GAP:    n_cfg.double_gap_ms = i_cfg_data;
                CFG_SETTLE:        n_cfg.settle_ms     = i_cfg_data;
                CFG_PRESSED_LEVEL: n_cfg.pressed_level = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= RST_DEBOUNCE;
            r_cfg.long_press_ms <= RST_LONG_PRESS;
            r_cfg.double_gap_ms <= RST_DOUBLE_GAP;
            r_cfg.settle_ms     <= RST_SETTLE;
            r_cfg.pressed_level <= RST_PRESSED_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bpc_fsm.sv =====
// phase machine and event decision for one poll
// depends on bpc_pkg
module bpc_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [bpc_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                        i_pin_level,
    input  bpc_pkg::t_cfg               i_cfg,
    output logic [bpc_pkg::EVENT_W-1:0] o_event_code,
    output bpc_pkg::t_status            o_status
);
    import bpc_pkg::*;

    t_status             r_st;
    t_status             n_st;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   n_start;
    logic [TIME_W-1:0]   elapsed;
    logic                pressed;
    logic                gt_debounce;
    logic                gt_long;
    logic                gt_double;
    logic                gt_settle;
    logic [EVENT_W-1:0]  ev;

    // elapsed time wraps modulo 2^32
    assign elapsed     = i_now_ms - r_start;
    assign pressed     = (i_pin_level == i_cfg.pressed_level);
    assign gt_debounce = elapsed > {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms};
    assign gt_long     = elapsed > {{(TIME_W-MS_W){1'b0}}, i_cfg.long_press_ms};
    assign gt_double   = elapsed > {{(TIME_W-MS_W){1'b0}}, i_cfg.double_gap_ms};
    assign gt_settle   = elapsed > {{(TIME_W-MS_W){1'b0}}, i_cfg.settle_ms};

    always_comb begin
        n_st    = r_st;
        n_start = r_start;
        ev      = EV_NONE;
        case (r_st.phase)
            PH_HELD: begin
                if (pressed) begin
                    if (gt_long && !r_st.long_fired) begin
                        ev              = EV_LONG;
                        n_st.long_fired = 1'b1;
                    end
                end else begin
                    if (gt_debounce && !r_st.short_fired && !r_st.long_fired) begin
                        ev               = EV_SHORT;
                        n_st.short_fired = 1'b1;
                    end
                    n_st.phase = PH_RELEASED;
                end
            end
            PH_RELEASED: begin
                if (pressed) begin
                    if (gt_double && !r_st.double_fired) begin
                        ev                = EV_DOUBLE;
                        n_st.double_fired = 1'b1;
                    end
                end else if (gt_settle) begin
                    n_st.phase        = PH_IDLE;
                    n_st.short_fired  = 1'b0;
                    n_st.long_fired   = 1'b0;
                    n_st.double_fired = 1'b0;
                end
            end
            default: begin
                if (pressed && gt_debounce) begin
                    n_st.phase = PH_HELD;
                    n_start    = i_now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase        <= PH_IDLE;
            r_st.short_fired  <= 1'b0;
            r_st.long_fired   <= 1'b0;
            r_st.double_fired <= 1'b0;
            r_start           <= '0;
        end else if (i_step) begin
            r_st    <= n_st;
            r_start <= n_start;
        end
    end

    assign o_event_code = ev;
    assign o_status     = r_st;

endmodule

// ===== rtl/button_press_classifier_core.sv =====
// top level of the button press classifier: input register, phase machine, result register
// depends on bpc_pkg, bpc_cfg, bpc_fsm and button_press_classifier_core_assert.svh
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------
// input    | in        | i_valid / o_stall      | i_now_ms, i_pin_level
// result   | out       | o_valid / i_stall      | o_event_code
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one poll per cycle while o_stall is low; each poll yields one result
// (input register, then phase compare into the result register)
// o_stall rises only when the input register holds a poll and the result register is stalled
// synchronous active-low reset clears control state and restores register defaults
// config writes are always ready and take effect the following cycle
`include "button_press_classifier_core_assert.svh"
module button_press_classifier_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bpc_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                           i_pin_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bpc_pkg::EVENT_W-1:0]    o_event_code,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpc_pkg::MS_W-1:0]       i_cfg_data
);
    import bpc_pkg::*;

    logic               r_in_valid;
    logic [TIME_W-1:0]  r_now_ms;
    logic               r_pin_level;
    logic               r_out_valid;
    logic [EVENT_W-1:0] r_event;
    logic               n_in_valid;
    logic               n_out_valid;
    logic               out_ready;
    logic               advance;
    logic               in_accept;
    logic [EVENT_W-1:0] fsm_event;
    t_cfg               cfg;
    t_status            status;
    logic               any_fired;
    logic               long_out;

    assign out_ready = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_accept = i_valid && !o_stall;

    assign n_in_valid  = in_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = out_ready ? advance : r_out_valid;

    bpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bpc_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_now_ms     (r_now_ms),
        .i_pin_level  (r_pin_level),
        .i_cfg        (cfg),
        .o_event_code (fsm_event),
        .o_status     (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_now_ms    <= i_now_ms;
            r_pin_level <= i_pin_level;
        end
        if (advance) begin
            r_event <= fsm_event;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_code = r_event;
    assign o_cfg_ready  = 1'b1;

    assign any_fired = status.short_fired || status.long_fired || status.double_fired;
    assign long_out  = r_out_valid && (r_event == EV_LONG);

    `BPC_ASSERT(a_stall_needs_item, i_clk, i_rst_n, o_stall |-> r_in_valid)
    `BPC_ASSERT(a_idle_flags_clear, i_clk, i_rst_n, (status.phase == PH_IDLE) |-> !any_fired)
    `BPC_ASSERT(a_double_in_released, i_clk, i_rst_n, status.double_fired |-> (status.phase == PH_RELEASED))
    `BPC_ASSERT(a_long_event_flagged, i_clk, i_rst_n, long_out |-> status.long_fired)
    `BPC_ASSERT_ALWAYS(a_phase_reachable, i_clk, !i_rst_n || (status.phase != PH_UNUSED))

endmodule

// ===== test/tb_button_press_classifier_core.sv =====
// self-checking bench for button_press_classifier_core: directed press gestures, then
// random gesture sequences across register settings, checked against an in-bench predictor
// depends on bpc_pkg and the button_press_classifier_core rtl
module tb_button_press_classifier_core;
    import bpc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT    = 2000;
    localparam int unsigned END_SETTLE_CYCLES = 8;
    localparam int unsigned SWEEP_SETTINGS    = 8;
    localparam int unsigned POLLS_PER_SETTING = 106;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_PRESSED_LEVEL + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNMAPPED  = {CFG_IDX_W{1'b1}};
    localparam logic [MS_W-1:0]      MS_MAX             = {MS_W{1'b1}};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [TIME_W-1:0]    i_now_ms    = '0;
    logic                 i_pin_level = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [EVENT_W-1:0]   o_event_code;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [MS_W-1:0]      i_cfg_data  = '0;

    // predictor state
    t_cfg               regs;
    logic [PHASE_W-1:0] btn_phase;
    logic [TIME_W-1:0]  press_t0;
    logic               short_done;
    logic               long_done;
    logic               double_done;

    logic [EVENT_W-1:0] pending_events[$];
    logic [EVENT_W-1:0] want_event;
    logic [TIME_W-1:0]  clock_ms     = '0;
    int unsigned        polls_sent   = 0;
    int unsigned        burst_left   = 0;
    int unsigned        err_count    = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        stall_mode   = 1;
    int unsigned        stall_run    = 0;

    button_press_classifier_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_now_ms     (i_now_ms),
        .i_pin_level  (i_pin_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_code (o_event_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [EVENT_W-1:0] classify_poll(input logic [TIME_W-1:0] now,
                                                         input logic lvl);
        logic               pressed;
        logic [TIME_W-1:0]  elapsed;
        logic [EVENT_W-1:0] ev;
        pressed = (lvl == regs.pressed_level);
        elapsed = now - press_t0;
        ev      = EV_NONE;
        case (btn_phase)
            PH_HELD: begin
                if (pressed) begin
                    if (elapsed > {16'b0, regs.long_press_ms} && !long_done) begin
                        ev        = EV_LONG;
                        long_done = 1'b1;
                    end
                end else begin
                    if (elapsed > {16'b0, regs.debounce_ms} && !short_done && !long_done) begin
                        ev         = EV_SHORT;
                        short_done = 1'b1;
                    end
                    btn_phase = PH_RELEASED;
                end
            end
            PH_RELEASED: begin
                if (pressed) begin
                    if (elapsed > {16'b0, regs.double_gap_ms} && !double_done) begin
                        ev          = EV_DOUBLE;
                        double_done = 1'b1;
                    end
                end else if (elapsed > {16'b0, regs.settle_ms}) begin
                    btn_phase   = PH_IDLE;
                    short_done  = 1'b0;
                    long_done   = 1'b0;
                    double_done = 1'b0;
                end
            end
            // idle, and the unused code that acts as idle
            default: begin
                if (pressed && elapsed > {16'b0, regs.debounce_ms}) begin
                    btn_phase = PH_HELD;
                    press_t0  = now;
                end
            end
        endcase
        return ev;
    endfunction

    // offset that lands on, just past, below or well past a threshold
    function automatic logic [TIME_W-1:0] near_threshold(input logic [MS_W-1:0] thr);
        logic [TIME_W-1:0] t;
        t = {16'b0, thr};
        case ($urandom_range(0, 4))
            0:       return t;
            1:       return t + 1;
            2:       return $urandom_range(0, t);
            default: return t + $urandom_range(1, 400);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic reset_dut();
        regs        = '{debounce_ms: RST_DEBOUNCE, long_press_ms: RST_LONG_PRESS,
                        double_gap_ms: RST_DOUBLE_GAP, settle_ms: RST_SETTLE,
                        pressed_level: RST_PRESSED_LEVEL};
        btn_phase   = PH_IDLE;
        press_t0    = '0;
        short_done  = 1'b0;
        long_done   = 1'b0;
        double_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // valid stays high inside a burst; the gap between bursts lowers it
    task automatic send_poll(input logic [TIME_W-1:0] now, input logic lvl);
        i_valid     <= 1'b1;
        i_now_ms    <= now;
        i_pin_level <= lvl;
        do @(posedge i_clk); while (o_stall);
        pending_events.push_back(classify_poll(now, lvl));
        polls_sent++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_events();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
    endtask

    // back-to-back writes keep valid high; cfg_close ends the batch
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE:      regs.debounce_ms   = data;
            CFG_LONG_PRESS:    regs.long_press_ms = data;
            CFG_DOUBLE_GAP:    regs.double_gap_ms = data;
            CFG_SETTLE:        regs.settle_ms     = data;
            CFG_PRESSED_LEVEL: regs.pressed_level = data[0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_short_press();
        send_poll(32'd10, 1'b0);      // too early after reset
        send_poll(32'd50, 1'b0);      // exactly at debounce, no start
        send_poll(32'd51, 1'b0);
        send_poll(32'd101, 1'b1);     // release at debounce, no short press
        send_poll(32'd900, 1'b1);
        send_poll(32'd1000, 1'b0);
        send_poll(32'd1051, 1'b1);
        send_poll(32'd1552, 1'b1);
    endtask

    task automatic test_long_press();
        send_poll(32'd3000, 1'b0);
        send_poll(32'd5000, 1'b0);    // at the long threshold
        send_poll(32'd5001, 1'b0);
        send_poll(32'd6000, 1'b0);    // long press already fired
        send_poll(32'd6100, 1'b1);    // no short press after a long one
        send_poll(32'd7000, 1'b1);
    endtask

    task automatic test_double_press();
        send_poll(32'd8000, 1'b0);
        send_poll(32'd8100, 1'b1);
        send_poll(32'd8250, 1'b0);    // at the double gap
        send_poll(32'd8251, 1'b0);
        send_poll(32'd8300, 1'b0);
        send_poll(32'd8400, 1'b1);    // still inside settle
        send_poll(32'd8501, 1'b1);
    endtask

    task automatic test_timestamp_wrap();
        send_poll(32'hFFFF_FF00, 1'b0);
        send_poll(32'h0000_0010, 1'b1);
        send_poll(32'h0000_0300, 1'b1);
    endtask

    task automatic test_unmapped_index();
        drain_events();
        cfg_write(CFG_FIRST_UNMAPPED, MS_MAX);
        cfg_write(CFG_LAST_UNMAPPED, 16'($urandom));
        cfg_close();
    endtask

    // one press gesture with timing steered around the current thresholds
    task automatic play_gesture();
        logic        down;
        int unsigned shape;
        down  = regs.pressed_level;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            // noise: arbitrary timestamps and levels
            repeat ($urandom_range(1, 5)) begin
                clock_ms = $urandom;
                send_poll(clock_ms, 1'($urandom_range(0, 1)));
            end
            return;
        end
        if ($urandom_range(0, 3) == 0)
            clock_ms = press_t0 + near_threshold(regs.debounce_ms);
        else
            clock_ms = clock_ms + near_threshold(regs.debounce_ms);
        send_poll(clock_ms, down);
        if (btn_phase != PH_HELD) begin
            clock_ms = press_t0 + regs.debounce_ms + 1 + $urandom_range(0, 99);
            send_poll(clock_ms, down);
        end
        repeat ($urandom_range(0, 3)) begin
            clock_ms = press_t0 + ((shape >= 7) ? near_threshold(regs.long_press_ms)
                                                : $urandom_range(0, regs.long_press_ms));
            send_poll(clock_ms, down);
        end
        clock_ms = press_t0 + ((shape >= 7) ? regs.long_press_ms + $urandom_range(1, 300)
                                            : near_threshold(regs.debounce_ms));
        send_poll(clock_ms, ~down);
        if (shape >= 4) begin
            repeat ($urandom_range(1, 3)) begin
                clock_ms = press_t0 + near_threshold(regs.double_gap_ms);
                send_poll(clock_ms, ($urandom_range(0, 3) == 0) ? ~down : down);
            end
        end
        clock_ms = press_t0 + near_threshold(regs.settle_ms);
        send_poll(clock_ms, ~down);
        clock_ms = press_t0 + regs.settle_ms + 1 + $urandom_range(0, 200);
        send_poll(clock_ms, ~down);
    endtask

    task automatic test_config_sweep();
        int unsigned target;
        logic        lvl;
        for (int unsigned p = 0; p < SWEEP_SETTINGS; p++) begin
            drain_events();
            stall_mode = p % 3;
            lvl        = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            case (p)
                0: begin
                    cfg_write(CFG_DEBOUNCE, '0);
                    cfg_write(CFG_LONG_PRESS, '0);
                    cfg_write(CFG_DOUBLE_GAP, '0);
                    cfg_write(CFG_SETTLE, '0);
                end
                1: begin
                    cfg_write(CFG_DEBOUNCE, MS_MAX);
                    cfg_write(CFG_LONG_PRESS, MS_MAX);
                    cfg_write(CFG_DOUBLE_GAP, MS_MAX);
                    cfg_write(CFG_SETTLE, MS_MAX);
                end
                default: begin
                    cfg_write(CFG_DEBOUNCE, 16'($urandom_range(0, 80)));
                    cfg_write(CFG_LONG_PRESS, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(100, 1500)));
                    cfg_write(CFG_DOUBLE_GAP, 16'($urandom_range(0, 400)));
                    cfg_write(CFG_SETTLE, 16'($urandom_range(0, 900)));
                end
            endcase
            // upper data bits must not reach the level register
            cfg_write(CFG_PRESSED_LEVEL, {15'($urandom), lvl});
            if (p % 2 == 0)
                cfg_write(3'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_UNMAPPED)),
                          16'($urandom));
            cfg_close();
            target   = polls_sent + POLLS_PER_SETTING;
            clock_ms = $urandom;
            while (polls_sent < target) play_gesture();
        end
    endtask

    // receiver stall pattern, switched by the running test
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_run <= 0;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_run == 0) begin
                        i_stall   <= !i_stall;
                        stall_run <= i_stall ? $urandom_range(1, 10) : $urandom_range(1, 12);
                    end else begin
                        stall_run <= stall_run - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("event %0d with no poll pending", o_event_code));
            end else begin
                want_event = pending_events.pop_front();
                if (o_event_code !== want_event)
                    report_mismatch($sformatf("event_code got %0d want %0d",
                                              o_event_code, want_event));
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("button_press_classifier_core regression: fail");
        $finish;
    end

    initial begin
        reset_dut();
        test_short_press();
        test_long_press();
        test_double_press();
        test_timestamp_wrap();
        test_unmapped_index();
        test_config_sweep();
        drain_events();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
        if (err_count == 0) begin
            $display("button_press_classifier_core regression: pass");
        end else begin
            $display("button_press_classifier_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== button_press_classifier_core.f =====
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_cfg.sv
rtl/bpc_fsm.sv
rtl/button_press_classifier_core.sv
test/tb_button_press_classifier_core.sv
